// ===== rtl/escu8_pkg.sv =====
// Shared types and constants for the escape sequence to UTF-8 decoder.
package escu8_pkg;

  // Longest run of output bytes that one input beat can cause.
  localparam int RUN_MAX = 5;

  // Input beat: one byte of escaped text and its end marker.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_beat_t;

  // Output beat: one byte of UTF-8 and the marker for the last byte of a run.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } out_beat_t;

  // A run of output bytes handed from the parser to the output side.
  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] bytes;
    logic [2:0]              count;
  } run_t;

  // Parser modes.
  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_ESC  = 3'd1,
    MODE_U4   = 3'd2,
    MODE_U8   = 3'd3,
    MODE_SBS  = 3'd4,
    MODE_SU   = 3'd5,
    MODE_SDIG = 3'd6
  } mode_t;

  // Characters that the parser looks for.
  localparam logic [7:0] CHR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHR_LOWER_U   = 8'h75;
  localparam logic [7:0] CHR_UPPER_U   = 8'h55;
  localparam logic [7:0] CHR_LOWER_N   = 8'h6E;
  localparam logic [7:0] CHR_LOWER_T   = 8'h74;
  localparam logic [7:0] CHR_LOWER_R   = 8'h72;
  localparam logic [7:0] CHR_LOWER_B   = 8'h62;
  localparam logic [7:0] CHR_LOWER_F   = 8'h66;
  localparam logic [7:0] CHR_LOWER_V   = 8'h76;
  localparam logic [7:0] CHR_LOWER_A   = 8'h61;

  // Control codes that the letter escapes stand for.
  localparam logic [7:0] CTL_LF  = 8'h0A;
  localparam logic [7:0] CTL_TAB = 8'h09;
  localparam logic [7:0] CTL_CR  = 8'h0D;
  localparam logic [7:0] CTL_BS  = 8'h08;
  localparam logic [7:0] CTL_FF  = 8'h0C;
  localparam logic [7:0] CTL_VT  = 8'h0B;
  localparam logic [7:0] CTL_BEL = 8'h07;

  // Code point limits.
  localparam logic [31:0] CP_1B_MAX    = 32'h0000_007F;
  localparam logic [31:0] CP_2B_MAX    = 32'h0000_07FF;
  localparam logic [31:0] CP_3B_MAX    = 32'h0000_FFFF;
  localparam logic [31:0] CP_MAX       = 32'h0010_FFFF;
  localparam logic [31:0] CP_SUPP_BASE = 32'h0001_0000;
  localparam logic [31:0] SUR_HI_FIRST = 32'h0000_D800;
  localparam logic [31:0] SUR_HI_LAST  = 32'h0000_DBFF;
  localparam logic [31:0] SUR_LO_FIRST = 32'h0000_DC00;
  localparam logic [31:0] SUR_LO_LAST  = 32'h0000_DFFF;

endpackage

// ===== rtl/escu8_front.sv =====
// Parser front end: accepts input beats, tracks escape state, builds output runs.
module escu8_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  escu8_pkg::in_beat_t in_beat,
  input  logic               queue_full,
  output logic               push,
  output escu8_pkg::run_t    run
);
  import escu8_pkg::*;

  // Working copy of the parser state plus the run being built.
  typedef struct packed {
    mode_t                   mode;
    logic [3:0]              cnt;
    logic [31:0]             acc;
    logic [15:0]             hi;
    logic [RUN_MAX-1:0][7:0] bytes;
    logic [2:0]              n;
    logic                    again;
  } ctx_t;

  mode_t       mode, mode_next;
  logic [3:0]  digit_count, digit_count_next;
  logic [31:0] hex_accumulator, hex_accumulator_next;
  logic [15:0] high_surrogate, high_surrogate_next;
  logic        accept;
  ctx_t        c0, c1, c2, c3, c4;

  // Hex digit value, with bit 4 set when the byte is a hex digit.
  function automatic logic [4:0] hex_of(logic [7:0] b);
    logic [4:0] r;
    r = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, b[3:0]};
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      r = {1'b1, 4'(b[3:0] + 4'd9)};
    end
    return r;
  endfunction

  // Append one byte; bytes past the end of the run are dropped.
  function automatic ctx_t put_byte(ctx_t c, logic [7:0] b);
    ctx_t r;
    r = c;
    if (c.n < 3'(RUN_MAX)) begin
      r.bytes[c.n] = b;
      r.n = c.n + 3'd1;
    end
    return r;
  endfunction

  // UTF-8 encoding of a code point; values above the Unicode range give nothing.
  function automatic ctx_t put_code(ctx_t c, logic [31:0] cp);
    ctx_t r;
    r = c;
    if (cp <= CP_1B_MAX) begin
      r = put_byte(r, cp[7:0]);
    end else if (cp <= CP_2B_MAX) begin
      r = put_byte(r, {3'b110, cp[10:6]});
      r = put_byte(r, {2'b10, cp[5:0]});
    end else if (cp <= CP_3B_MAX) begin
      r = put_byte(r, {4'b1110, cp[15:12]});
      r = put_byte(r, {2'b10, cp[11:6]});
      r = put_byte(r, {2'b10, cp[5:0]});
    end else if (cp <= CP_MAX) begin
      r = put_byte(r, {5'b11110, cp[20:18]});
      r = put_byte(r, {2'b10, cp[17:12]});
      r = put_byte(r, {2'b10, cp[11:6]});
      r = put_byte(r, {2'b10, cp[5:0]});
    end
    return r;
  endfunction

  function automatic ctx_t add_digit(ctx_t c, logic [3:0] h);
    ctx_t r;
    r = c;
    r.acc = {c.acc[27:0], h};
    r.cnt = c.cnt + 4'd1;
    return r;
  endfunction

  // Finish a short escape: literal text, a code, or a pending high surrogate.
  function automatic ctx_t end_short(ctx_t c);
    ctx_t r;
    r = c;
    if (c.cnt == 4'd0) begin
      r = put_byte(r, CHR_BACKSLASH);
      r = put_byte(r, CHR_LOWER_U);
      r.mode = MODE_IDLE;
    end else if (c.acc >= SUR_HI_FIRST && c.acc <= SUR_HI_LAST) begin
      r.hi = c.acc[15:0];
      r.mode = MODE_SBS;
    end else begin
      r = put_code(r, c.acc);
      r.mode = MODE_IDLE;
    end
    r.cnt = '0;
    r.acc = '0;
    return r;
  endfunction

  // Finish a long escape.
  function automatic ctx_t end_long(ctx_t c);
    ctx_t r;
    r = c;
    if (c.cnt == 4'd0) begin
      r = put_byte(r, CHR_BACKSLASH);
      r = put_byte(r, CHR_UPPER_U);
    end else begin
      r = put_code(r, c.acc);
    end
    r.mode = MODE_IDLE;
    r.cnt = '0;
    r.acc = '0;
    return r;
  endfunction

  // Join a surrogate pair, or encode the high half alone.
  function automatic ctx_t end_pair(ctx_t c);
    ctx_t r;
    r = c;
    if (c.cnt != 4'd0 && c.acc >= SUR_LO_FIRST && c.acc <= SUR_LO_LAST) begin
      r = put_code(r, 32'({c.hi[9:0], c.acc[9:0]}) + CP_SUPP_BASE);
    end else begin
      r = put_code(r, {16'd0, c.hi});
    end
    r.mode = MODE_IDLE;
    r.cnt = '0;
    r.acc = '0;
    return r;
  endfunction

  // One pass over the byte; again is set when the byte must be looked at anew.
  function automatic ctx_t parse_pass(ctx_t c, logic [7:0] b);
    ctx_t       r;
    logic [4:0] h;
    r = c;
    r.again = 1'b0;
    h = hex_of(b);
    unique case (c.mode)
      MODE_ESC: begin
        r.mode = MODE_IDLE;
        r.cnt = '0;
        r.acc = '0;
        if (b == CHR_LOWER_N) r = put_byte(r, CTL_LF);
        else if (b == CHR_LOWER_T) r = put_byte(r, CTL_TAB);
        else if (b == CHR_LOWER_R) r = put_byte(r, CTL_CR);
        else if (b == CHR_LOWER_B) r = put_byte(r, CTL_BS);
        else if (b == CHR_LOWER_F) r = put_byte(r, CTL_FF);
        else if (b == CHR_LOWER_V) r = put_byte(r, CTL_VT);
        else if (b == CHR_LOWER_A) r = put_byte(r, CTL_BEL);
        else if (b == CHR_LOWER_U) r.mode = MODE_U4;
        else if (b == CHR_UPPER_U) r.mode = MODE_U8;
        else begin
          r = put_byte(r, CHR_BACKSLASH);
          r.again = 1'b1;
        end
      end
      MODE_U4: begin
        if (h[4]) begin
          r = add_digit(r, h[3:0]);
          if (r.cnt >= 4'd4) r = end_short(r);
        end else begin
          r = end_short(r);
          r.again = 1'b1;
        end
      end
      MODE_U8: begin
        if (h[4]) begin
          r = add_digit(r, h[3:0]);
          if (r.cnt >= 4'd8) r = end_long(r);
        end else begin
          r = end_long(r);
          r.again = 1'b1;
        end
      end
      MODE_SBS: begin
        if (b == CHR_BACKSLASH) begin
          r.mode = MODE_SU;
        end else if (h[4]) begin
          r.cnt = '0;
          r.acc = '0;
          r = add_digit(r, h[3:0]);
          r.mode = MODE_SDIG;
        end else begin
          r = end_pair(r);
          r.again = 1'b1;
        end
      end
      MODE_SU: begin
        if (b == CHR_LOWER_U) begin
          r.cnt = '0;
          r.acc = '0;
          r.mode = MODE_SDIG;
        end else if (h[4]) begin
          r.cnt = '0;
          r.acc = '0;
          r = add_digit(r, h[3:0]);
          r.mode = MODE_SDIG;
        end else begin
          r = end_pair(r);
          r.again = 1'b1;
        end
      end
      MODE_SDIG: begin
        if (h[4]) begin
          r = add_digit(r, h[3:0]);
          if (r.cnt >= 4'd4) r = end_pair(r);
        end else begin
          r = end_pair(r);
          r.again = 1'b1;
        end
      end
      default: begin
        if (b == CHR_BACKSLASH) begin
          r.mode = MODE_ESC;
          r.cnt = '0;
          r.acc = '0;
        end else begin
          r.mode = MODE_IDLE;
          r = put_byte(r, b);
        end
      end
    endcase
    return r;
  endfunction

  // End of text: emit whatever is still pending and return to idle.
  function automatic ctx_t flush_pending(ctx_t c);
    ctx_t r;
    r = c;
    unique case (c.mode)
      MODE_ESC: r = put_byte(r, CHR_BACKSLASH);
      MODE_U4: begin
        r = end_short(r);
        if (r.mode == MODE_SBS) r = end_pair(r);
      end
      MODE_U8: r = end_long(r);
      MODE_SBS, MODE_SU, MODE_SDIG: r = end_pair(r);
      default: ;
    endcase
    r.mode = MODE_IDLE;
    r.cnt = '0;
    r.acc = '0;
    r.hi = '0;
    return r;
  endfunction

  // A byte is re-examined at most twice, so three passes cover every chain.
  always_comb begin
    c0 = '{mode: mode, cnt: digit_count, acc: hex_accumulator, hi: high_surrogate,
           bytes: '0, n: 3'd0, again: 1'b0};
    c1 = parse_pass(c0, in_beat.in_byte);
    c2 = c1.again ? parse_pass(c1, in_beat.in_byte) : c1;
    c3 = c2.again ? parse_pass(c2, in_beat.in_byte) : c2;
    c4 = in_beat.end_of_text ? flush_pending(c3) : c3;
  end

  // Handshake: hold off input while the queue has no room.
  assign in_stall = queue_full;
  assign accept   = in_valid && !queue_full;
  assign push     = accept && (c4.n != 3'd0);
  assign run      = '{bytes: c4.bytes, count: c4.n};

  // Next parser state.
  always_comb begin
    mode_next            = mode;
    digit_count_next     = digit_count;
    hex_accumulator_next = hex_accumulator;
    high_surrogate_next  = high_surrogate;
    if (accept) begin
      mode_next            = c4.mode;
      digit_count_next     = c4.cnt;
      hex_accumulator_next = c4.acc;
      high_surrogate_next  = c4.hi;
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_IDLE;
      digit_count     <= '0;
      hex_accumulator <= '0;
      high_surrogate  <= '0;
    end else begin
      mode            <= mode_next;
      digit_count     <= digit_count_next;
      hex_accumulator <= hex_accumulator_next;
      high_surrogate  <= high_surrogate_next;
    end
  end

endmodule

// ===== rtl/escu8_queue.sv =====
// Small run queue between the parser and the output side.
module escu8_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  escu8_pkg::run_t push_run,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output escu8_pkg::run_t head_run
);
  import escu8_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  run_t          entries [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_run   = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_run;
    end
  end

endmodule

// ===== rtl/escu8_back.sv =====
// Output side: takes runs from the queue and sends them one byte per beat.
module escu8_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  escu8_pkg::run_t      head_run,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output escu8_pkg::out_beat_t out_beat
);
  import escu8_pkg::*;

  run_t       cur;
  logic       active;
  logic [2:0] idx;
  logic       take;
  logic       cur_last;

  // The output register can load when empty or when its beat is taken.
  assign take     = !out_valid || !out_stall;
  assign cur_last = (idx == cur.count - 3'd1);
  assign pop      = head_valid && (!active || (take && cur_last));

  // Control: run in progress, byte index, output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        out_valid <= active;
      end
      if (pop) begin
        active <= 1'b1;
        idx    <= '0;
      end else if (take && active) begin
        if (cur_last) begin
          active <= 1'b0;
        end else begin
          idx <= idx + 3'd1;
        end
      end
    end
  end

  // Payload: current run and output beat.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head_run;
    end
    if (take && active) begin
      out_beat <= '{out_byte: cur.bytes[idx], run_last: cur_last};
    end
  end

endmodule

// ===== rtl/escape_sequence_to_utf8_decoder.sv =====
// Top level of the escape sequence to UTF-8 decoder.
// Decodes backslash escapes (letter escapes, \u with up to four hex digits, \U with
// up to eight, surrogate pairs) in a byte stream into UTF-8; other bytes pass through.
// An input beat is taken whenever the run queue has room, and the
// bytes it causes (zero to five) leave through a single output register at one
// byte per cycle while out_stall is low, the last one marked by run_last.
// Sustained throughput is thus one input beat per cycle for beats that make at
// most one byte, and less for beats that make more; the one-byte output lane sets
// that limit, and the QUEUE_DEPTH-entry run queue absorbs short bursts in between.
// A beat with end_of_text set flushes any pending escape with its own output.
module escape_sequence_to_utf8_decoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  escu8_pkg::in_beat_t  in_beat,
  output logic                 out_valid,
  input  logic                 out_stall,
  output escu8_pkg::out_beat_t out_beat
);
  import escu8_pkg::*;

  logic push, queue_full, pop, head_valid;
  run_t push_run, head_run;

  // Parser front end.
  escu8_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_beat    (in_beat),
    .queue_full (queue_full),
    .push       (push),
    .run        (push_run)
  );

  // Run queue.
  escu8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_run   (push_run),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_run   (head_run)
  );

  // Byte serializer.
  escu8_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_run   (head_run),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_beat   (out_beat)
  );

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the escape sequence to UTF-8 decoder.
module tb;
  import escu8_pkg::*;

  // One row of stimulus: an input beat, plus its output run where that is typed in.
  typedef struct packed {
    logic [7:0]  in_byte;
    logic        eot;
    logic        typed;
    logic [2:0]  cnt;
    logic [39:0] want;  // First output byte in the low bits.
  } text_row_t;

  localparam int N_DIRECTED = 26;

  // Directed opening: two raw bytes, a letter escape, an unknown letter, a joined
  // surrogate pair, and an out-of-range long escape closed by the end marker.
  localparam text_row_t DIRECTED [N_DIRECTED] = '{
    '{8'h41, 1'b0, 1'b1, 3'd1, 40'h41},
    '{8'hFF, 1'b0, 1'b1, 3'd1, 40'hFF},
    '{CHR_BACKSLASH, 1'b0, 1'b1, 3'd0, 40'd0},
    '{CHR_LOWER_N, 1'b0, 1'b1, 3'd1, {32'd0, CTL_LF}},
    '{CHR_BACKSLASH, 1'b0, 1'b1, 3'd0, 40'd0},
    '{8'h71, 1'b0, 1'b1, 3'd2, {24'd0, 8'h71, CHR_BACKSLASH}},
    '{CHR_BACKSLASH, 1'b0, 1'b1, 3'd0, 40'd0},
    '{CHR_LOWER_U, 1'b0, 1'b1, 3'd0, 40'd0},
    '{8'h44, 1'b0, 1'b0, 3'd0, 40'd0},
    '{8'h38, 1'b0, 1'b0, 3'd0, 40'd0},
    '{8'h33, 1'b0, 1'b0, 3'd0, 40'd0},
    '{8'h44, 1'b0, 1'b0, 3'd0, 40'd0},
    '{CHR_BACKSLASH, 1'b0, 1'b0, 3'd0, 40'd0},
    '{CHR_LOWER_U, 1'b0, 1'b0, 3'd0, 40'd0},
    '{8'h44, 1'b0, 1'b0, 3'd0, 40'd0},
    '{8'h45, 1'b0, 1'b0, 3'd0, 40'd0},
    '{8'h30, 1'b0, 1'b0, 3'd0, 40'd0},
    '{8'h30, 1'b0, 1'b0, 3'd0, 40'd0},
    '{CHR_BACKSLASH, 1'b0, 1'b1, 3'd0, 40'd0},
    '{CHR_UPPER_U, 1'b0, 1'b1, 3'd0, 40'd0},
    '{8'h31, 1'b0, 1'b0, 3'd0, 40'd0},
    '{8'h31, 1'b0, 1'b0, 3'd0, 40'd0},
    '{8'h30, 1'b0, 1'b0, 3'd0, 40'd0},
    '{8'h30, 1'b0, 1'b0, 3'd0, 40'd0},
    '{8'h30, 1'b0, 1'b0, 3'd0, 40'd0},
    '{8'h30, 1'b1, 1'b1, 3'd0, 40'd0}
  };

  localparam logic [7:0] LETTERS [7] = '{
    CHR_LOWER_N, CHR_LOWER_T, CHR_LOWER_R, CHR_LOWER_B, CHR_LOWER_F, CHR_LOWER_V, CHR_LOWER_A
  };

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  in_beat_t   in_beat;
  logic       out_valid;
  logic       out_stall;
  out_beat_t  out_beat;

  // Decoder state as the predictor sees it.
  mode_t       dec_mode;
  logic [3:0]  dig_n;
  logic [31:0] hex_acc;
  logic [15:0] hi_sur;
  logic [7:0]  run_bytes[$];

  out_beat_t   utf8_q[$];
  text_row_t   text_q[$];
  text_row_t   row_q[$];
  int          errors = 0;
  int          send_idle = 0;
  int          recv_idle = 0;
  bit          hold_on = 1'b0;
  event        hold_ev;

  escape_sequence_to_utf8_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Digit value of an ASCII hex character, or -1 for anything else.
  function automatic int hex_val(logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return int'(b - 8'h30);
    if (b >= 8'h61 && b <= 8'h66) return int'(b - 8'h61) + 10;
    if (b >= 8'h41 && b <= 8'h46) return int'(b - 8'h41) + 10;
    return -1;
  endfunction

  // A run holds at most RUN_MAX bytes; anything past that is dropped.
  function automatic void put_byte(logic [7:0] b);
    if (run_bytes.size() < RUN_MAX) run_bytes.push_back(b);
  endfunction

  // UTF-8 encoding; code points past the Unicode range give nothing.
  function automatic void put_code(logic [31:0] cp);
    if (cp <= CP_1B_MAX) begin
      put_byte(cp[7:0]);
    end else if (cp <= CP_2B_MAX) begin
      put_byte(8'hC0 | cp[10:6]);
      put_byte(8'h80 | cp[5:0]);
    end else if (cp <= CP_3B_MAX) begin
      put_byte(8'hE0 | cp[15:12]);
      put_byte(8'h80 | cp[11:6]);
      put_byte(8'h80 | cp[5:0]);
    end else if (cp <= CP_MAX) begin
      put_byte(8'hF0 | cp[20:18]);
      put_byte(8'h80 | cp[17:12]);
      put_byte(8'h80 | cp[11:6]);
      put_byte(8'h80 | cp[5:0]);
    end
  endfunction

  function automatic void clear_digits();
    dig_n = '0;
    hex_acc = '0;
  endfunction

  function automatic void add_nibble(int h);
    hex_acc = {hex_acc[27:0], h[3:0]};
    dig_n = dig_n + 4'd1;
  endfunction

  // Close a short escape; a high surrogate waits for its partner.
  function automatic void finish_short();
    if (dig_n == 0) begin
      put_byte(CHR_BACKSLASH);
      put_byte(CHR_LOWER_U);
      dec_mode = MODE_IDLE;
    end else if (hex_acc >= SUR_HI_FIRST && hex_acc <= SUR_HI_LAST) begin
      hi_sur = hex_acc[15:0];
      dec_mode = MODE_SBS;
    end else begin
      put_code(hex_acc);
      dec_mode = MODE_IDLE;
    end
    clear_digits();
  endfunction

  function automatic void finish_long();
    if (dig_n == 0) begin
      put_byte(CHR_BACKSLASH);
      put_byte(CHR_UPPER_U);
    end else begin
      put_code(hex_acc);
    end
    dec_mode = MODE_IDLE;
    clear_digits();
  endfunction

  // Join the pair if the second value is a low surrogate, else encode the high half alone.
  function automatic void finish_pair();
    if (dig_n != 0 && hex_acc >= SUR_LO_FIRST && hex_acc <= SUR_LO_LAST) begin
      put_code(((({16'd0, hi_sur} - SUR_HI_FIRST) << 10) | (hex_acc - SUR_LO_FIRST))
               + CP_SUPP_BASE);
    end else begin
      put_code({16'd0, hi_sur});
    end
    dec_mode = MODE_IDLE;
    clear_digits();
  endfunction

  // One byte through the parser; a byte that ends an escape may be handled again.
  function automatic void parse_byte(logic [7:0] b);
    bit again;
    int h;
    again = 1'b1;
    while (again) begin
      h = hex_val(b);
      again = 1'b0;
      case (dec_mode)
        MODE_ESC: begin
          dec_mode = MODE_IDLE;
          clear_digits();
          case (b)
            CHR_LOWER_N: put_byte(CTL_LF);
            CHR_LOWER_T: put_byte(CTL_TAB);
            CHR_LOWER_R: put_byte(CTL_CR);
            CHR_LOWER_B: put_byte(CTL_BS);
            CHR_LOWER_F: put_byte(CTL_FF);
            CHR_LOWER_V: put_byte(CTL_VT);
            CHR_LOWER_A: put_byte(CTL_BEL);
            CHR_LOWER_U: dec_mode = MODE_U4;
            CHR_UPPER_U: dec_mode = MODE_U8;
            default: begin
              put_byte(CHR_BACKSLASH);
              again = 1'b1;
            end
          endcase
        end
        MODE_U4: begin
          if (h >= 0) begin
            add_nibble(h);
            if (dig_n >= 4) finish_short();
          end else begin
            finish_short();
            again = 1'b1;
          end
        end
        MODE_U8: begin
          if (h >= 0) begin
            add_nibble(h);
            if (dig_n >= 8) finish_long();
          end else begin
            finish_long();
            again = 1'b1;
          end
        end
        MODE_SBS: begin
          if (b == CHR_BACKSLASH) begin
            dec_mode = MODE_SU;
          end else if (h >= 0) begin
            clear_digits();
            add_nibble(h);
            dec_mode = MODE_SDIG;
          end else begin
            finish_pair();
            again = 1'b1;
          end
        end
        MODE_SU: begin
          if (b == CHR_LOWER_U) begin
            clear_digits();
            dec_mode = MODE_SDIG;
          end else if (h >= 0) begin
            clear_digits();
            add_nibble(h);
            dec_mode = MODE_SDIG;
          end else begin
            finish_pair();
            again = 1'b1;
          end
        end
        MODE_SDIG: begin
          if (h >= 0) begin
            add_nibble(h);
            if (dig_n >= 4) finish_pair();
          end else begin
            finish_pair();
            again = 1'b1;
          end
        end
        default: begin
          if (b == CHR_BACKSLASH) begin
            dec_mode = MODE_ESC;
            clear_digits();
          end else begin
            dec_mode = MODE_IDLE;
            put_byte(b);
          end
        end
      endcase
    end
  endfunction

  // Bytes caused by one input beat, left in run_bytes; the end marker flushes.
  function automatic void decode_step(in_beat_t b);
    run_bytes.delete();
    parse_byte(b.in_byte);
    if (b.end_of_text) begin
      case (dec_mode)
        MODE_ESC: put_byte(CHR_BACKSLASH);
        MODE_U4: begin
          finish_short();
          if (dec_mode == MODE_SBS) finish_pair();
        end
        MODE_U8: finish_long();
        MODE_SBS, MODE_SU, MODE_SDIG: finish_pair();
        default: ;
      endcase
      dec_mode = MODE_IDLE;
      clear_digits();
      hi_sur = '0;
    end
  endfunction

  // Random text generation.
  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 10) return 8'h30 + n;
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (hex_val(b) >= 0);
    return b;
  endfunction

  function automatic void put_text(logic [7:0] b);
    text_row_t r;
    r = '0;
    r.in_byte = b;
    r.eot = ($urandom_range(0, 99) < 3);
    text_q.push_back(r);
  endfunction

  function automatic void put_digits(logic [31:0] v, int n);
    for (int i = n - 1; i >= 0; i--) put_text(hex_char(v[4*i +: 4]));
  endfunction

  // Mostly well-formed escapes with random content, some noise and broken ones.
  function automatic void fill_text(int count);
    int goal;
    int pick;
    int n;
    logic [31:0] v;
    goal = text_q.size() + count;
    while (text_q.size() < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        put_text(8'($urandom_range(0, 255)));
      end else if (pick < 35) begin
        put_text(CHR_BACKSLASH);
        put_text(LETTERS[$urandom_range(0, 6)]);
      end else if (pick < 50) begin
        n = $urandom_range(1, 4);
        put_text(CHR_BACKSLASH);
        put_text(CHR_LOWER_U);
        put_digits($urandom(), n);
        if (n < 4 || $urandom_range(0, 3) == 0) put_text(non_hex());
      end else if (pick < 62) begin
        n = $urandom_range(1, 8);
        v = $urandom_range(0, 1) ? $urandom_range(0, 32'h10FFFF) : $urandom();
        put_text(CHR_BACKSLASH);
        put_text(CHR_UPPER_U);
        put_digits(v >> (4 * (8 - n)), n);
        if (n < 8 || $urandom_range(0, 3) == 0) put_text(non_hex());
      end else if (pick < 80) begin
        // Surrogate pair, with the second backslash and u each optional.
        put_text(CHR_BACKSLASH);
        put_text(CHR_LOWER_U);
        put_digits(SUR_HI_FIRST + $urandom_range(0, 1023), 4);
        if ($urandom_range(0, 9) < 8) begin
          put_text(CHR_BACKSLASH);
          if ($urandom_range(0, 9) < 8) put_text(CHR_LOWER_U);
        end
        v = ($urandom_range(0, 9) < 8) ? SUR_LO_FIRST + $urandom_range(0, 1023)
                                        : $urandom_range(0, 16'hFFFF);
        n = ($urandom_range(0, 9) < 7) ? 4 : $urandom_range(1, 3);
        put_digits(v >> (4 * (4 - n)), n);
        if (n < 4) put_text(non_hex());
      end else if (pick < 88) begin
        put_text(CHR_BACKSLASH);
        put_text(8'($urandom_range(0, 255)));
      end else if (pick < 94) begin
        put_text(CHR_BACKSLASH);
        put_text($urandom_range(0, 1) ? CHR_LOWER_U : CHR_UPPER_U);
        put_text(non_hex());
      end else begin
        // Lone high surrogate, then a backslash that leads nowhere.
        put_text(CHR_BACKSLASH);
        put_text(CHR_LOWER_U);
        put_digits(SUR_HI_FIRST + $urandom_range(0, 1023), 4);
        put_text(CHR_BACKSLASH);
        put_text(non_hex());
      end
      if ($urandom_range(0, 9) == 0) text_q[text_q.size() - 1].eot = 1'b1;
    end
  endfunction

  // Offer every queued row in order; each beat holds until it is taken.
  task automatic send_text();
    text_row_t r;
    while (text_q.size() > 0) begin
      r = text_q.pop_front();
      while ($urandom_range(0, 99) < send_idle) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
      row_q.push_back(r);
      in_valid <= 1'b1;
      in_beat <= '{in_byte: r.in_byte, end_of_text: r.eot};
      @(posedge clk);
      while (in_stall) @(posedge clk);
      @(negedge clk);
    end
  endtask

  // Receiver stalls, with a long hold-off on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= hold_on || ($urandom_range(0, 99) < recv_idle);
    end
  end

  initial begin
    @(hold_ev);
    @(posedge clk);
    hold_on = 1'b1;
    repeat (64) @(posedge clk);
    hold_on = 1'b0;
  end

  // Predict on each accepted input beat and check each accepted output beat.
  always @(posedge clk) begin
    text_row_t row;
    out_beat_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (utf8_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected beat: byte %h last %b", out_beat.out_byte, out_beat.run_last);
        end else begin
          want = utf8_q.pop_front();
          if (out_beat.out_byte !== want.out_byte || out_beat.run_last !== want.run_last) begin
            errors++;
            if (errors <= 10)
              $display("beat mismatch: byte %h last %b, expected byte %h last %b",
                       out_beat.out_byte, out_beat.run_last, want.out_byte, want.run_last);
          end
        end
      end
      if (in_valid && !in_stall) begin
        row = row_q.pop_front();
        decode_step(in_beat);
        if (row.typed) begin
          run_bytes.delete();
          for (int i = 0; i < row.cnt; i++) run_bytes.push_back(row.want[8*i +: 8]);
        end
        foreach (run_bytes[i]) begin
          want.out_byte = run_bytes[i];
          want.run_last = (i == run_bytes.size() - 1);
          utf8_q.push_back(want);
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_beat = '0;
    dec_mode = MODE_IDLE;
    clear_digits();
    hi_sur = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Sender mostly busy, receiver mostly stalled; directed rows lead.
    send_idle = 7;
    recv_idle = 81;
    foreach (DIRECTED[i]) text_q.push_back(DIRECTED[i]);
    fill_text(60);
    send_text();

    // Sender mostly idle, receiver mostly ready; then drain fully.
    send_idle = 81;
    recv_idle = 7;
    fill_text(55);
    send_text();
    in_valid <= 1'b0;
    while (utf8_q.size() != 0) @(posedge clk);
    @(negedge clk);

    // Full rate, with a long receiver hold-off at the start.
    send_idle = 0;
    recv_idle = 0;
    -> hold_ev;
    fill_text(55);
    send_text();
    in_valid <= 1'b0;

    while (utf8_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
